/* rtl/qsf_pkg.sv */
// Shared types, constants and arithmetic helpers of the quadratic spline flattener.
`default_nettype none
package qsf_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int FRAC_BITS      = 12;
   localparam int STACK_DEPTH    = 20;
   localparam int THR_WIDTH      = 31;
   localparam int BUDGET_WIDTH   = 6;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int FLAT_UNITS     = 5;
   localparam int BUDGET_MAX     = 61;
   localparam int CMD_FIFO_DEPTH = 2;

   localparam int FILL_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int IDX_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int MAG_WIDTH  = (COORD_WIDTH + 1 > THR_WIDTH) ? COORD_WIDTH + 1 : THR_WIDTH;

   localparam logic [THR_WIDTH-1:0] THR_RESET =
      THR_WIDTH'(FLAT_UNITS) << FRAC_BITS;
   localparam logic [BUDGET_WIDTH-1:0] BUDGET_RESET = BUDGET_WIDTH'(BUDGET_MAX);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FLAT_THRESHOLD = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POP_BUDGET     = CSR_IDX_WIDTH'(1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
      coord_type d_x;
      coord_type d_y;
   } seg_type;

   typedef enum logic [1:0] {
      CMD_POINT,
      CMD_TAIL,
      CMD_SEGMENT
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      logic      fin;
      coord_type pt_x;
      coord_type pt_y;
      seg_type   seg;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_EMIT_MID,
      ST_TAIL_END,
      ST_TAIL_POINT,
      ST_FLUSH
   } back_state_type;

   function automatic coord_type halve(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] s;
      s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
      return s[COORD_WIDTH:1];
   endfunction

   function automatic logic is_close(input coord_type a, input coord_type b,
                                     input logic [THR_WIDTH-1:0] thr);
      logic signed [COORD_WIDTH:0] d;
      logic [COORD_WIDTH:0]        m;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      m = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - d : d;
      return MAG_WIDTH'(m) < MAG_WIDTH'(thr);
   endfunction

endpackage
`default_nettype wire

/* rtl/qsf_if.sv */
// Valid/ready channel interfaces for points, vertices and register writes.
`default_nettype none
interface qsf_req_if import qsf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      final_point;
   modport source (output valid, point_x, point_y, final_point, input ready);
   modport sink (input valid, point_x, point_y, final_point, output ready);
endinterface

interface qsf_rsp_if import qsf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   logic      run_last;
   logic      curve_end;
   modport source (output valid, out_x, out_y, run_last, curve_end, input ready);
   modport sink (input valid, out_x, out_y, run_last, curve_end, output ready);
endinterface

interface qsf_csr_if import qsf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/quadratic_spline_flattener.sv */
// A first point reaches the output via the command queue, the engine's command
// register, its pending vertex slot and the output register. A segment costs
// its stack pops (at most 61, bounded by pop_budget) and a midpoint emit per
// flat piece; the single stack pop per cycle, while it can emit, sets the rate.
// Reset clears all control state and loads the register reset values;
// the stack needs no clearing pass.
`default_nettype none
module quadratic_spline_flattener import qsf_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   qsf_req_if.sink   req_ch,
   qsf_rsp_if.source rsp_ch,
   qsf_csr_if.sink   csr_ch
);
   logic [THR_WIDTH-1:0]    threshold_ff;
   logic [BUDGET_WIDTH-1:0] budget_ff, budget_eff;
   logic                    f_valid, f_ready, b_valid, b_ready;
   cmd_type                 f_data, b_data;

   assign csr_ch.ready = 1'b1;
   assign budget_eff   = (budget_ff > BUDGET_WIDTH'(BUDGET_MAX)) ?
                         BUDGET_WIDTH'(BUDGET_MAX) : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
         budget_ff    <= BUDGET_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_FLAT_THRESHOLD) begin
            threshold_ff <= csr_ch.data[THR_WIDTH-1:0];
         end else if (csr_ch.index == CSR_POP_BUDGET) begin
            budget_ff <= csr_ch.data[BUDGET_WIDTH-1:0];
         end
      end
   end

   qsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (f_valid),
      .cmd_data  (f_data),
      .cmd_ready (f_ready)
   );

   qsf_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  (f_data),
      .push_ready (f_ready),
      .pop_valid  (b_valid),
      .pop_data   (b_data),
      .pop_ready  (b_ready)
   );

   qsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_data  (b_data),
      .cmd_ready (b_ready),
      .threshold (threshold_ff),
      .budget    (budget_eff),
      .rsp       (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_budget_clamped: assert property (@(posedge clock) disable iff (reset)
      budget_eff <= BUDGET_WIDTH'(BUDGET_MAX))
      else $error("pop budget above limit");

   a_rsp_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      b_valid && !b_ready |=> b_valid && $stable(b_data))
      else $error("queued command changed while waiting");
`endif
endmodule
`default_nettype wire

/* rtl/qsf_cmd_fifo.sv */
// Short command queue between the point classifier and the subdivision engine.
`default_nettype none
module qsf_cmd_fifo import qsf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_data,
   output logic         push_ready,
   output logic         pop_valid,
   output cmd_type      pop_data,
   input  wire logic    pop_ready
);
   localparam int PTR_WIDTH = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type                entry_ff [CMD_FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(CMD_FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* rtl/qsf_front.sv */
// Point classifier: tracks curve position; at most one command per point.
`default_nettype none
module qsf_front import qsf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   qsf_req_if.sink   req,
   output logic      cmd_valid,
   output cmd_type   cmd_data,
   input  wire logic cmd_ready
);
   logic [1:0] seen_ff, seen_in;
   coord_type  prev_x_ff, prev_y_ff, mid_x_ff, mid_y_ff;
   coord_type  prev_x_in, prev_y_in, mid_x_in, mid_y_in;
   logic       accept;
   seg_type    seg;

   assign req.ready = cmd_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      seg.a_x = mid_x_ff;
      seg.a_y = mid_y_ff;
      seg.b_x = halve(mid_x_ff, prev_x_ff);
      seg.b_y = halve(mid_y_ff, prev_y_ff);
      seg.d_x = halve(prev_x_ff, req.point_x);
      seg.d_y = halve(prev_y_ff, req.point_y);
      seg.c_x = halve(prev_x_ff, seg.d_x);
      seg.c_y = halve(prev_y_ff, seg.d_y);

      seen_in   = seen_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      mid_x_in  = mid_x_ff;
      mid_y_in  = mid_y_ff;
      cmd_valid = 1'b0;
      cmd_data.kind = CMD_POINT;
      cmd_data.fin  = req.final_point;
      cmd_data.pt_x = req.point_x;
      cmd_data.pt_y = req.point_y;
      cmd_data.seg  = seg;

      if (req.valid) begin
         prev_x_in = req.point_x;
         prev_y_in = req.point_y;
         case (seen_ff)
            2'd0: begin
               cmd_valid = 1'b1;
               seen_in   = 2'd1;
            end
            2'd1: begin
               mid_x_in = halve(prev_x_ff, req.point_x);
               mid_y_in = halve(prev_y_ff, req.point_y);
               cmd_data.kind    = CMD_TAIL;
               cmd_data.seg.d_x = mid_x_in;
               cmd_data.seg.d_y = mid_y_in;
               cmd_valid = req.final_point;
               seen_in   = 2'd2;
            end
            default: begin
               mid_x_in = seg.d_x;
               mid_y_in = seg.d_y;
               cmd_data.kind = CMD_SEGMENT;
               cmd_valid = 1'b1;
            end
         endcase
         if (req.final_point) begin
            seen_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         mid_x_ff  <= '0;
         mid_y_ff  <= '0;
      end else if (accept) begin
         seen_ff   <= seen_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         mid_x_ff  <= mid_x_in;
         mid_y_ff  <= mid_y_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/qsf_back.sv */
// Subdivision engine: pops the segment stack at most once per cycle, while it can emit, and emits vertices.
`default_nettype none
module qsf_back import qsf_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cmd_valid,
   input  wire cmd_type                 cmd_data,
   output logic                         cmd_ready,
   input  wire logic [THR_WIDTH-1:0]    threshold,
   input  wire logic [BUDGET_WIDTH-1:0] budget,
   qsf_rsp_if.source                    rsp
);
   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff;
   seg_type                 stack_ff [STACK_DEPTH];
   logic [FILL_WIDTH-1:0]   fill_ff, fill_in;
   logic [BUDGET_WIDTH-1:0] pops_ff, pops_in;
   coord_type               mx_ff, my_ff, mx, my;
   logic                    pend_valid_ff, pend_valid_in;
   coord_type               pend_x_ff, pend_y_ff, pend_x_in, pend_y_in;
   logic                    out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic                    out_end_ff, out_end_in;
   coord_type               out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                    slot_free, can_emit, emit_en, flush_en, flat;
   coord_type               emit_x, emit_y;
   logic                    we0, we1, take_mid;
   logic [IDX_WIDTH-1:0]    idx0, idx1, top_idx;
   seg_type                 d0, d1, top;

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_x     = out_x_ff;
   assign rsp.out_y     = out_y_ff;
   assign rsp.run_last  = out_last_ff;
   assign rsp.curve_end = out_end_ff;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign can_emit  = !pend_valid_ff || slot_free;
   assign top_idx   = IDX_WIDTH'(fill_ff - 1'b1);
   assign top       = stack_ff[top_idx];
   assign mx        = halve(top.b_x, top.c_x);
   assign my        = halve(top.b_y, top.c_y);
   assign flat      = is_close(top.a_x, mx, threshold) && is_close(top.a_y, my, threshold) &&
                      is_close(mx, top.d_x, threshold) && is_close(my, top.d_y, threshold);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      pops_in   = pops_ff;
      cmd_ready = 1'b0;
      emit_en   = 1'b0;
      flush_en  = 1'b0;
      emit_x    = cmd_ff.pt_x;
      emit_y    = cmd_ff.pt_y;
      take_mid  = 1'b0;
      we0  = 1'b0;
      we1  = 1'b0;
      idx0 = top_idx;
      idx1 = IDX_WIDTH'(fill_ff);
      d0   = cmd_data.seg;
      d0.a_x = mx;
      d0.a_y = my;
      d0.b_x = halve(mx, top.c_x);
      d0.b_y = halve(my, top.c_y);
      d0.c_x = halve(top.c_x, top.d_x);
      d0.c_y = halve(top.c_y, top.d_y);
      d0.d_x = top.d_x;
      d0.d_y = top.d_y;
      d1.a_x = top.a_x;
      d1.a_y = top.a_y;
      d1.b_x = halve(top.a_x, top.b_x);
      d1.b_y = halve(top.a_y, top.b_y);
      d1.c_x = halve(top.b_x, mx);
      d1.c_y = halve(top.b_y, my);
      d1.d_x = mx;
      d1.d_y = my;

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd_data.kind)
                  CMD_POINT: state_in = ST_TAIL_POINT;
                  CMD_TAIL:  state_in = ST_TAIL_END;
                  default: begin
                     we0      = 1'b1;
                     idx0     = '0;
                     d0       = cmd_data.seg;
                     fill_in  = FILL_WIDTH'(1);
                     pops_in  = '0;
                     state_in = ST_POP;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (fill_ff == '0 || pops_ff >= budget) begin
               state_in = cmd_ff.fin ? ST_TAIL_END : ST_FLUSH;
            end else if (can_emit) begin
               pops_in = pops_ff + 1'b1;
               if (flat) begin
                  emit_en  = 1'b1;
                  emit_x   = top.a_x;
                  emit_y   = top.a_y;
                  take_mid = 1'b1;
                  fill_in  = fill_ff - 1'b1;
                  state_in = ST_EMIT_MID;
               end else begin
                  we0 = 1'b1;
                  if (fill_ff < FILL_WIDTH'(STACK_DEPTH)) begin
                     we1     = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         ST_EMIT_MID: begin
            emit_x = mx_ff;
            emit_y = my_ff;
            if (can_emit) begin
               emit_en  = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_TAIL_END: begin
            emit_x = cmd_ff.seg.d_x;
            emit_y = cmd_ff.seg.d_y;
            if (can_emit) begin
               emit_en  = 1'b1;
               state_in = ST_TAIL_POINT;
            end
         end
         ST_TAIL_POINT: begin
            if (can_emit) begin
               emit_en  = 1'b1;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || slot_free) begin
               flush_en = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_last_in   = out_last_ff;
      out_end_in    = out_end_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      if (emit_en) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_x_in     = pend_x_ff;
            out_y_in     = pend_y_ff;
            out_last_in  = 1'b0;
            out_end_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_x_in     = emit_x;
         pend_y_in     = emit_y;
      end
      if (flush_en && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_x_in      = pend_x_ff;
         out_y_in      = pend_y_ff;
         out_last_in   = 1'b1;
         out_end_in    = cmd_ff.fin;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         pops_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pops_ff       <= pops_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_ready && cmd_valid) begin
         cmd_ff <= cmd_data;
      end
      if (take_mid) begin
         mx_ff <= mx;
         my_ff <= my;
      end
      if (we0) begin
         stack_ff[idx0] <= d0;
      end
      if (we1) begin
         stack_ff[idx1] <= d1;
      end
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end
endmodule
`default_nettype wire

/* sim/qsf_tb_if.sv */
// Testbench package with the expected vertex record.
`default_nettype none
package qsf_tb_pkg;
   import qsf_pkg::*;
   typedef struct {
      coord_type x;
      coord_type y;
      logic      run_last;
      logic      curve_end;
   } vertex_type;
endpackage
`default_nettype wire

/* sim/quadratic_spline_flattener_tb.sv */
// Self-checking testbench of the spline flattener with a built-in polyline predictor.
`default_nettype none
module quadratic_spline_flattener_tb;
   import qsf_pkg::*;
   import qsf_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   qsf_req_if req_ch();
   qsf_rsp_if rsp_ch();
   qsf_csr_if csr_ch();

   quadratic_spline_flattener i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   logic [THR_WIDTH-1:0]    model_thr;
   logic [BUDGET_WIDTH-1:0] model_budget;
   int unsigned             model_seen;
   coord_type               model_prev_x, model_prev_y, model_mid_x, model_mid_y;
   vertex_type              pending_vertices[$];
   int                      error_count = 0;
   int                      vertex_count = 0;
   int                      point_count = 0;
   int                      idle_cycles = 0;
   logic                    rsp_stall_on = 1'b1;

   function automatic coord_type mid_of(coord_type a, coord_type b);
      logic signed [COORD_WIDTH:0] s;
      s = $signed(a) + $signed(b);
      return coord_type'(s >>> 1);
   endfunction

   function automatic logic near(coord_type a, coord_type b);
      logic signed [COORD_WIDTH+1:0] d;
      d = $signed(a) - $signed(b);
      if (d < 0) d = -d;
      return d < $signed({3'b000, model_thr});
   endfunction

   function automatic void add_vertex(ref vertex_type v[$], input coord_type x, coord_type y);
      vertex_type e;
      if (v.size() >= 64) return;
      e.x = x; e.y = y; e.run_last = 1'b0; e.curve_end = 1'b0;
      v.push_back(e);
   endfunction

   function automatic void flatten_segment(ref vertex_type v[$], input seg_type seg);
      seg_type stk[$];
      seg_type p, q;
      coord_type mx, my;
      int unsigned budget, pops;
      budget = (model_budget > BUDGET_MAX) ? BUDGET_MAX : model_budget;
      pops = 0;
      stk.push_back(seg);
      while (stk.size() > 0) begin
         p = stk.pop_back();
         if (pops >= budget) break;
         pops++;
         mx = mid_of(p.b_x, p.c_x);
         my = mid_of(p.b_y, p.c_y);
         if (near(p.a_x, mx) && near(p.a_y, my) && near(mx, p.d_x) && near(my, p.d_y)) begin
            add_vertex(v, p.a_x, p.a_y);
            add_vertex(v, mx, my);
         end else begin
            q.a_x = mx; q.a_y = my;
            q.b_x = mid_of(mx, p.c_x); q.b_y = mid_of(my, p.c_y);
            q.c_x = mid_of(p.c_x, p.d_x); q.c_y = mid_of(p.c_y, p.d_y);
            q.d_x = p.d_x; q.d_y = p.d_y;
            if (stk.size() < STACK_DEPTH) stk.push_back(q);
            q.a_x = p.a_x; q.a_y = p.a_y;
            q.b_x = mid_of(p.a_x, p.b_x); q.b_y = mid_of(p.a_y, p.b_y);
            q.c_x = mid_of(p.b_x, mx); q.c_y = mid_of(p.b_y, my);
            q.d_x = mx; q.d_y = my;
            if (stk.size() < STACK_DEPTH) stk.push_back(q);
         end
      end
   endfunction

   function automatic void predict_point(coord_type x, coord_type y, logic fin);
      vertex_type v[$];
      seg_type    seg;
      if (model_seen == 0) begin
         add_vertex(v, x, y);
         model_prev_x = x; model_prev_y = y;
         model_seen = 1;
      end else if (model_seen == 1) begin
         model_mid_x = mid_of(model_prev_x, x);
         model_mid_y = mid_of(model_prev_y, y);
         model_prev_x = x; model_prev_y = y;
         model_seen = 2;
         if (fin) begin
            add_vertex(v, model_mid_x, model_mid_y);
            add_vertex(v, x, y);
         end
      end else begin
         seg.a_x = model_mid_x; seg.a_y = model_mid_y;
         seg.b_x = mid_of(model_mid_x, model_prev_x);
         seg.b_y = mid_of(model_mid_y, model_prev_y);
         seg.d_x = mid_of(model_prev_x, x); seg.d_y = mid_of(model_prev_y, y);
         seg.c_x = mid_of(model_prev_x, seg.d_x);
         seg.c_y = mid_of(model_prev_y, seg.d_y);
         flatten_segment(v, seg);
         model_mid_x = seg.d_x; model_mid_y = seg.d_y;
         model_prev_x = x; model_prev_y = y;
         if (fin) begin
            add_vertex(v, model_mid_x, model_mid_y);
            add_vertex(v, x, y);
         end
      end
      if (v.size() > 0) begin
         v[v.size()-1].run_last = 1'b1;
         v[v.size()-1].curve_end = fin;
      end
      if (fin) model_seen = 0;
      foreach (v[i]) pending_vertices.push_back(v[i]);
   endfunction

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_point(coord_type x, coord_type y, logic fin);
      random_gap();
      req_ch.valid <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      req_ch.final_point <= fin;
      do @(posedge clock); while (!req_ch.ready);
      predict_point(x, y, fin);
      point_count++;
   endtask

   task automatic drain_vertices();
      req_ch.valid <= 1'b0;
      while (pending_vertices.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      drain_vertices();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_FLAT_THRESHOLD) model_thr = value[THR_WIDTH-1:0];
      else if (idx == CSR_POP_BUDGET) model_budget = value[BUDGET_WIDTH-1:0];
   endtask

   function automatic coord_type rand_coord(int unsigned span);
      if (span == 0) return coord_type'($urandom());
      return coord_type'($signed($urandom_range(0, 2 * span)) - $signed(span));
   endfunction

   task automatic test_special_curves();
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      send_point(0, 0, 1'b0);
      send_point(32'sh0001_0000, 32'shFFFF_0000, 1'b0);
      send_point(32'sh0003_0000, 32'sh0000_4000, 1'b0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_point(-1, -1, 1'b1);
   endtask

   task automatic test_threshold_extremes();
      write_csr(CSR_FLAT_THRESHOLD, 32'h0);
      write_csr(CSR_POP_BUDGET, 32'd7);
      send_point(0, 0, 1'b0);
      send_point(32'sh0010_0000, 32'sh0020_0000, 1'b0);
      send_point(32'sh0030_0000, 32'shFFF0_0000, 1'b1);
      write_csr(CSR_FLAT_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(CSR_POP_BUDGET, 32'd0);
      send_point(5, 6, 1'b0);
      send_point(7, 8, 1'b0);
      send_point(9, 10, 1'b1);
      write_csr(CSR_POP_BUDGET, 32'd63);
      send_point(1, 2, 1'b0);
      send_point(3, 4, 1'b0);
      send_point(5, 6, 1'b1);
   endtask

   task automatic test_random_curves(int items);
      int sent, len, span;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
         span = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(12, 26));
         for (int k = 0; k < len; k++) begin
            send_point(rand_coord(span), rand_coord(span), k == len - 1);
            sent++;
         end
         if ($urandom_range(0, 15) == 0) drain_vertices();
      end
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_FLAT_THRESHOLD, $urandom_range(1 << 12, 1 << 22));
         write_csr(CSR_POP_BUDGET, $urandom_range(1, BUDGET_MAX));
         test_random_curves(50);
      end
      write_csr(CSR_FLAT_THRESHOLD, 32'h7FFF_FFFF);
      write_csr(CSR_POP_BUDGET, BUDGET_MAX);
      test_random_curves(20);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) rsp_stall_on <= ~rsp_stall_on;
         if (!rsp_stall_on) rsp_ch.ready <= 1'b1;
         else if ($urandom_range(0, 29) == 0) rsp_ch.ready <= 1'b0;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         vertex_count++;
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex x=%h y=%h", $time, rsp_ch.out_x, rsp_ch.out_y);
            error_count++;
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_ch.out_x !== e.x || rsp_ch.out_y !== e.y ||
                rsp_ch.run_last !== e.run_last || rsp_ch.curve_end !== e.curve_end) begin
               $display("%0t: expected x=%h y=%h last=%b end=%b, actual x=%h y=%h last=%b end=%b",
                        $time, e.x, e.y, e.run_last, e.curve_end, rsp_ch.out_x, rsp_ch.out_y,
                        rsp_ch.run_last, rsp_ch.curve_end);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("quadratic_spline_flattener regression: fail");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.final_point = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      model_thr = THR_RESET;
      model_budget = BUDGET_RESET;
      model_seen = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_curves();
      test_threshold_extremes();
      test_random_settings();
      drain_vertices();
      $display("Covered %0d points and %0d vertices over several threshold and budget settings.",
               point_count, vertex_count);
      if (error_count == 0) begin
         $display("quadratic_spline_flattener regression: pass");
      end else begin
         $display("quadratic_spline_flattener regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
